// File: rtl/lcha_pkg.sv
// Shared constants and controller/datapath handshake types for the column height allocator.
package lcha_pkg;

  localparam int ATLAS_SIZE_DEF = 256;
  localparam int DIM_W          = 9;
  localparam int CORNER_W       = 8;
  localparam int PAGE_W         = 8;

  localparam logic [PAGE_W-1:0] PAGE_MAX = 8'd255;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic win;
    logic skip;
    logic acc;
    logic wr_start;
    logic wr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic best_zero;
    logic win_done;
    logic hit;
    logic fit;
    logic wr_done;
    logic clr_last;
  } sts_t;

endpackage

// File: rtl/lcha_if.sv
// Request and result channel interfaces of the column height allocator.
interface lcha_req_if;
  import lcha_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;

  modport source (output valid, mode, rect_width, rect_height, input ready);
  modport sink   (input valid, mode, rect_width, rect_height, output ready);
endinterface

interface lcha_rsp_if;
  import lcha_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [CORNER_W-1:0] corner_s;
  logic [CORNER_W-1:0] corner_t;
  logic [PAGE_W-1:0]   page;

  modport source (output valid, ok, corner_s, corner_t, page, input ready);
  modport sink   (input valid, ok, corner_s, corner_t, page, output ready);
endinterface

// File: rtl/lcha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcha_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lcha_ctrl.sv
// Controller state machine that sequences clearing, scanning and raising of columns.
module lcha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  lcha_pkg::sts_t sts,
  output lcha_pkg::cmd_t cmd
);
  import lcha_pkg::*;

  localparam logic [2:0] S_INIT_CLR = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_CMP      = 3'd3;
  localparam logic [2:0] S_FIT      = 3'd4;
  localparam logic [2:0] S_WR       = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;
  localparam logic [2:0] S_PAGE_CLR = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_INIT_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_mode ? S_PAGE_CLR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end || sts.best_zero) begin
          state_nxt = S_FIT;
        end else if (sts.win_done) begin
          cmd.win = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.acc = 1'b1;
        end
        state_nxt = S_SCAN;
      end
      S_FIT: begin
        if (sts.fit) begin
          cmd.wr_start = 1'b1;
          state_nxt    = S_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WR: begin
        if (sts.wr_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.wr_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PAGE_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/lcha_dp.sv
// Datapath with the column height memory, scan counters, best window tracking and result register.
module lcha_dp #(
  parameter int ATLAS_SIZE = lcha_pkg::ATLAS_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_mode,
  input  logic [lcha_pkg::DIM_W-1:0]    in_rect_width,
  input  logic [lcha_pkg::DIM_W-1:0]    in_rect_height,
  input  lcha_pkg::cmd_t                cmd,
  output lcha_pkg::sts_t                sts,
  output logic                          out_ok,
  output logic [lcha_pkg::CORNER_W-1:0] out_corner_s,
  output logic [lcha_pkg::CORNER_W-1:0] out_corner_t,
  output logic [lcha_pkg::PAGE_W-1:0]   out_page
);
  import lcha_pkg::*;

  localparam int AW = $clog2(ATLAS_SIZE);
  localparam int IW = $clog2(ATLAS_SIZE + 1);
  localparam int HW = IW;
  localparam int XW = ((IW > DIM_W) ? IW : DIM_W) + 1;

  logic             mode_r;
  logic [DIM_W-1:0] w_r;
  logic [DIM_W-1:0] h_r;
  logic [IW-1:0]    starts_r;
  logic [IW-1:0]    s_r;
  logic [IW-1:0]    j_r;
  logic [HW-1:0]    top_r;
  logic [HW-1:0]    best_r;
  logic [AW-1:0]    best_s_r;
  logic             found_r;
  logic [IW-1:0]    col_r;
  logic [PAGE_W-1:0] page_r;

  logic                out_ok_r;
  logic [CORNER_W-1:0] out_cs_r;
  logic [CORNER_W-1:0] out_ct_r;
  logic [PAGE_W-1:0]   out_page_r;

  logic [XW-1:0] size_x;
  logic [XW-1:0] w_in_x;
  logic [IW-1:0] starts_calc;
  logic [XW-1:0] raised_x;
  logic [HW-1:0] raised_h;
  logic [IW-1:0] rd_idx;
  logic [HW-1:0] rd_data;
  logic          ram_we;
  logic [HW-1:0] ram_wdata;
  logic          fit;
  logic [XW-1:0] bs_x;
  logic [XW-1:0] bt_x;

  assign size_x      = XW'(ATLAS_SIZE);
  assign w_in_x      = XW'(in_rect_width);
  assign starts_calc = (w_in_x < size_x) ? IW'(size_x - w_in_x) : '0;
  assign raised_x    = XW'(best_r) + XW'(h_r);
  assign raised_h    = HW'(raised_x);
  assign rd_idx      = s_r + j_r;
  assign fit         = found_r && (raised_x <= size_x);
  assign bs_x        = XW'(best_s_r);
  assign bt_x        = XW'(best_r);

  assign ram_we    = cmd.clr_step | cmd.wr_step;
  assign ram_wdata = cmd.clr_step ? '0 : raised_h;

  lcha_ram #(
    .WIDTH (HW),
    .DEPTH (ATLAS_SIZE)
  ) u_height_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign sts.scan_end  = (s_r >= starts_r);
  assign sts.best_zero = (best_r == '0);
  assign sts.win_done  = (XW'(j_r) == XW'(w_r));
  assign sts.hit       = (rd_data >= best_r);
  assign sts.fit       = fit;
  assign sts.wr_done   = (XW'(j_r) == XW'(w_r));
  assign sts.clr_last  = (col_r == IW'(ATLAS_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      page_r <= '0;
    end else begin
      if (cmd.accept && in_mode) begin
        col_r <= '0;
        if (page_r != PAGE_MAX) begin
          page_r <= page_r + PAGE_W'(1);
        end
      end else if (cmd.wr_start) begin
        col_r <= IW'(best_s_r);
      end else if (cmd.clr_step || cmd.wr_step) begin
        col_r <= col_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      w_r      <= in_rect_width;
      h_r      <= in_rect_height;
      starts_r <= starts_calc;
      s_r      <= '0;
      j_r      <= '0;
      top_r    <= '0;
      best_r   <= HW'(ATLAS_SIZE);
      found_r  <= 1'b0;
    end
    if (cmd.win) begin
      if (top_r < best_r) begin
        best_r   <= top_r;
        best_s_r <= s_r[AW-1:0];
        found_r  <= 1'b1;
      end
      s_r   <= s_r + IW'(1);
      j_r   <= '0;
      top_r <= '0;
    end
    if (cmd.skip) begin
      s_r   <= s_r + j_r + IW'(1);
      j_r   <= '0;
      top_r <= '0;
    end
    if (cmd.acc) begin
      if (rd_data > top_r) begin
        top_r <= rd_data;
      end
      j_r <= j_r + IW'(1);
    end
    if (cmd.wr_start) begin
      j_r <= '0;
    end
    if (cmd.wr_step) begin
      j_r <= j_r + IW'(1);
    end
    if (cmd.load_out) begin
      out_ok_r   <= mode_r | fit;
      out_cs_r   <= (!mode_r && fit) ? bs_x[CORNER_W-1:0] : '0;
      out_ct_r   <= (!mode_r && fit) ? bt_x[CORNER_W-1:0] : '0;
      out_page_r <= page_r;
    end
  end

  assign out_ok       = out_ok_r;
  assign out_corner_s = out_cs_r;
  assign out_corner_t = out_ct_r;
  assign out_page     = out_page_r;

endmodule

// File: rtl/lightmap_column_height_allocator_unit.sv
// Top level of the lightmap column height allocator.
// The block places rectangles in a square atlas page of ATLAS_SIZE columns by keeping one fill
// height per column in a single-port-write, registered-read memory, and handles one item at a
// time. After reset a clearing pass writes every column to zero with in_ready low. A new-page
// item runs the same pass and then returns its result. An allocate item scans start columns by
// reading one column at a time, then raises the chosen columns at one per cycle. A column at or
// above the lowest height found so far moves the scan past that column, and the scan stops as
// soon as a window of height zero is found, so the number of column reads is close to ATLAS_SIZE
// for typical layouts; a staircase of falling heights can drive it toward the number of start
// columns times rect_width. The result waits in an output register, and the next item is taken
// while that register still holds an earlier result.
module lightmap_column_height_allocator_unit #(
  parameter int ATLAS_SIZE = lcha_pkg::ATLAS_SIZE_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lcha_req_if.sink   in_chan,
  lcha_rsp_if.source out_chan
);
  import lcha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lcha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcha_dp #(
    .ATLAS_SIZE (ATLAS_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_chan.mode),
    .in_rect_width  (in_chan.rect_width),
    .in_rect_height (in_chan.rect_height),
    .cmd            (cmd),
    .sts            (sts),
    .out_ok         (out_chan.ok),
    .out_corner_s   (out_chan.corner_s),
    .out_corner_t   (out_chan.corner_t),
    .out_page       (out_chan.page)
  );

endmodule

// File: rtl/lcha_checker.sv
// Port-level assertion checker for the column height allocator and its bind statement.
module lcha_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [lcha_pkg::CORNER_W-1:0] out_corner_s,
  input logic [lcha_pkg::CORNER_W-1:0] out_corner_t,
  input logic [lcha_pkg::PAGE_W-1:0]   out_page
);
  import lcha_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_corner_s)
                                && $stable(out_corner_t) && $stable(out_page))
    else $error("result changed while stalled");

  // A failed allocation reports a zero corner.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_corner_s == '0 && out_corner_t == '0)
    else $error("failed allocation with nonzero corner");

  // Reset starts the clearing pass with no result pending.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready or result pending right after reset");

  // A new-page transfer starts a clearing pass, so the next request is held off.
  a_page_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("request taken during the new-page clearing pass");

endmodule

bind lightmap_column_height_allocator_unit lcha_checker u_lcha_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_mode      (in_chan.mode),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_ok       (out_chan.ok),
  .out_corner_s (out_chan.corner_s),
  .out_corner_t (out_chan.corner_t),
  .out_page     (out_chan.page)
);
